/* hw/rtl/tlru_pkg.sv */
// ----------------------------------------------------------------------------
// Two-level TLB package
// Request codes, controller states and the command and status groups that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package tlru_pkg;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_INV   = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOK,
    ST_NEW_INIT,
    ST_NEW_SCAN,
    ST_NEW_FILL,
    ST_V_INIT,
    ST_V_SCAN,
    ST_DEMOTE,
    ST_D_INIT,
    ST_D_SCAN,
    ST_D_FILL,
    ST_FILL1,
    ST_EMIT,
    ST_INV1,
    ST_INV2
  } state_t;

  typedef enum logic [1:0] {
    OUT_XLATE,
    OUT_EVICT,
    OUT_KEY
  } out_sel_t;

  typedef struct packed {
    logic     accept;
    logic     look;
    logic     scan_init;
    logic     scan_step;
    logic     scan_l2;
    logic     fill_new;
    logic     demote_key;
    logic     merge;
    logic     demote_fill;
    logic     fill_first;
    logic     inv1;
    logic     inv2;
    logic     out_load;
    out_sel_t out_sel;
    logic     out_last;
  } cmd_t;

  typedef struct packed {
    logic l1_hit;
    logic l1_dirty;
    logic l2_hit;
    logic l2_dirty;
    logic scan_last;
    logic v_valid;
    logic evict_dirty;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/two_level_tlb_lru_unit.sv */
// ----------------------------------------------------------------------------
// Two-level TLB with timestamp LRU
// A first-level hit is looked up and its result loaded; no new transaction is
// taken while one is in progress. A second-level hit also scans the first
// level for an LRU victim and demotes it, scanning the second level too when
// the victim is not there; a double miss first scans and fills the second
// level. The LRU scanner checks one entry per cycle; write-backs and the result
// wait on any output stall. The next transaction can be accepted in the cycle
// after the result is loaded. Reset clears all entries, zeroes the access clock.
// ----------------------------------------------------------------------------
module two_level_tlb_lru_unit #(
  parameter int FIRST_ENTRIES  = 8,
  parameter int SECOND_ENTRIES = 32,
  parameter int OFFSET_BITS    = 12,
  parameter int PAGE_BITS      = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [31:0] vaddr,
  input  logic [19:0] page_number,
  input  logic [19:0] walk_page,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [31:0] address,
  output logic        l1_hit,
  output logic        l2_hit,
  output logic        last
);
  import tlru_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tlru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  tlru_dp #(
    .FIRST_ENTRIES  (FIRST_ENTRIES),
    .SECOND_ENTRIES (SECOND_ENTRIES),
    .OFFSET_BITS    (OFFSET_BITS),
    .PAGE_BITS      (PAGE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .vaddr       (vaddr),
    .page_number (page_number),
    .walk_page   (walk_page),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .address     (address),
    .l1_hit      (l1_hit),
    .l2_hit      (l2_hit),
    .last        (last)
  );

  a_busy_after_translate: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (op == OP_READ || op == OP_STORE)) |=> in_stall)
    else $error("Translation transaction did not occupy the controller.");

  a_unused_op_free: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && op == OP_NONE) |=> !in_stall)
    else $error("Unused opcode left the controller busy.");

  a_translate_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !kind) |-> last)
    else $error("Translation result was not marked as the final result.");

  a_writeback_no_hit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind) |-> (!l1_hit && !l2_hit))
    else $error("Write-back result carried a hit flag.");

endmodule

/* hw/rtl/tlru_ctrl.sv */
// ----------------------------------------------------------------------------
// Two-level TLB controller
// Sequences lookup, victim scans, demotion, fills and result emission.
// ----------------------------------------------------------------------------
module tlru_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [1:0]    op,
  output logic          in_stall,
  output tlru_pkg::cmd_t cmd,
  input  tlru_pkg::sts_t sts
);
  import tlru_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (op == OP_INV) begin
            state_next = ST_INV1;
          end else if (op == OP_READ || op == OP_STORE) begin
            state_next = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        if (sts.l1_hit) begin
          state_next = ST_EMIT;
        end else if (sts.l2_hit) begin
          state_next = ST_V_INIT;
        end else begin
          state_next = ST_NEW_INIT;
        end
      end
      ST_NEW_INIT: state_next = ST_NEW_SCAN;
      ST_NEW_SCAN: begin
        if (sts.scan_last) begin
          state_next = ST_NEW_FILL;
        end
      end
      ST_NEW_FILL: begin
        if (!sts.evict_dirty || sts.out_free) begin
          state_next = ST_V_INIT;
        end
      end
      ST_V_INIT: state_next = ST_V_SCAN;
      ST_V_SCAN: begin
        if (sts.scan_last) begin
          state_next = ST_DEMOTE;
        end
      end
      ST_DEMOTE: begin
        if (!sts.v_valid || sts.l2_hit) begin
          state_next = ST_FILL1;
        end else begin
          state_next = ST_D_INIT;
        end
      end
      ST_D_INIT: state_next = ST_D_SCAN;
      ST_D_SCAN: begin
        if (sts.scan_last) begin
          state_next = ST_D_FILL;
        end
      end
      ST_D_FILL: begin
        if (!sts.evict_dirty || sts.out_free) begin
          state_next = ST_FILL1;
        end
      end
      ST_FILL1: state_next = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_INV1: begin
        if (!(sts.l1_hit && sts.l1_dirty) || sts.out_free) begin
          state_next = ST_INV2;
        end
      end
      ST_INV2: begin
        if (!(sts.l2_hit && sts.l2_dirty) || sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE: cmd.accept = in_valid;
      ST_LOOK: cmd.look = 1'b1;
      ST_NEW_INIT: begin
        cmd.scan_init = 1'b1;
        cmd.scan_l2   = 1'b1;
      end
      ST_NEW_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.scan_l2   = 1'b1;
      end
      ST_NEW_FILL: begin
        if (!sts.evict_dirty || sts.out_free) begin
          cmd.fill_new = 1'b1;
          cmd.out_load = sts.evict_dirty;
          cmd.out_sel  = OUT_EVICT;
        end
      end
      ST_V_INIT: cmd.scan_init = 1'b1;
      ST_V_SCAN: cmd.scan_step = 1'b1;
      ST_DEMOTE: begin
        cmd.demote_key = 1'b1;
        cmd.merge      = sts.v_valid && sts.l2_hit;
      end
      ST_D_INIT: begin
        cmd.scan_init = 1'b1;
        cmd.scan_l2   = 1'b1;
      end
      ST_D_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.scan_l2   = 1'b1;
      end
      ST_D_FILL: begin
        if (!sts.evict_dirty || sts.out_free) begin
          cmd.demote_fill = 1'b1;
          cmd.out_load    = sts.evict_dirty;
          cmd.out_sel     = OUT_EVICT;
        end
      end
      ST_FILL1: cmd.fill_first = 1'b1;
      ST_EMIT: begin
        cmd.out_load = sts.out_free;
        cmd.out_sel  = OUT_XLATE;
        cmd.out_last = 1'b1;
      end
      ST_INV1: begin
        if (!(sts.l1_hit && sts.l1_dirty) || sts.out_free) begin
          cmd.inv1     = 1'b1;
          cmd.out_load = sts.l1_hit && sts.l1_dirty;
          cmd.out_sel  = OUT_KEY;
          cmd.out_last = !(sts.l2_hit && sts.l2_dirty);
        end
      end
      ST_INV2: begin
        if (!(sts.l2_hit && sts.l2_dirty) || sts.out_free) begin
          cmd.inv2     = 1'b1;
          cmd.out_load = sts.l2_hit && sts.l2_dirty;
          cmd.out_sel  = OUT_KEY;
          cmd.out_last = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

/* hw/rtl/tlru_dp.sv */
// ----------------------------------------------------------------------------
// Two-level TLB datapath
// Entry arrays of both levels, access clock, match logic, LRU victim scanner
// and the output register.
// ----------------------------------------------------------------------------
module tlru_dp #(
  parameter int FIRST_ENTRIES  = 8,
  parameter int SECOND_ENTRIES = 32,
  parameter int OFFSET_BITS    = 12,
  parameter int PAGE_BITS      = 20
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [1:0]     op,
  input  logic [31:0]    vaddr,
  input  logic [19:0]    page_number,
  input  logic [19:0]    walk_page,
  input  tlru_pkg::cmd_t cmd,
  output tlru_pkg::sts_t sts,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           kind,
  output logic [31:0]    address,
  output logic           l1_hit,
  output logic           l2_hit,
  output logic           last
);
  import tlru_pkg::*;

  localparam int NMAX = (FIRST_ENTRIES > SECOND_ENTRIES) ? FIRST_ENTRIES : SECOND_ENTRIES;
  localparam int SW   = $clog2(NMAX);
  localparam int W1   = $clog2(FIRST_ENTRIES);
  localparam int W2   = $clog2(SECOND_ENTRIES);

  logic                   f_valid [FIRST_ENTRIES];
  logic                   f_dirty [FIRST_ENTRIES];
  logic [PAGE_BITS-1:0]   f_vpage [FIRST_ENTRIES];
  logic [PAGE_BITS-1:0]   f_ppage [FIRST_ENTRIES];
  logic [31:0]            f_stamp [FIRST_ENTRIES];
  logic                   s_valid [SECOND_ENTRIES];
  logic                   s_dirty [SECOND_ENTRIES];
  logic [PAGE_BITS-1:0]   s_vpage [SECOND_ENTRIES];
  logic [PAGE_BITS-1:0]   s_ppage [SECOND_ENTRIES];
  logic [31:0]            s_stamp [SECOND_ENTRIES];
  logic [31:0]            clock;

  logic [PAGE_BITS-1:0]   key;
  logic [OFFSET_BITS-1:0] off;
  logic                   wr;
  logic [PAGE_BITS-1:0]   walk;
  logic [PAGE_BITS-1:0]   pp;
  logic                   bd;
  logic                   h1;
  logic                   h2;
  logic [W1-1:0]          v;
  logic [W2-1:0]          k;
  logic [SW-1:0]          idx;
  logic [SW-1:0]          best;
  logic [31:0]            oldest;

  logic [PAGE_BITS+31:0]  va_wide;
  logic [PAGE_BITS+19:0]  pn_wide;
  logic [PAGE_BITS+19:0]  wp_wide;
  logic [PAGE_BITS-1:0]   va_page;
  logic [PAGE_BITS-1:0]   l2_key;
  logic [W1-1:0]          a;
  logic [W2-1:0]          b;
  logic                   m1;
  logic                   m2;
  logic                   cur_valid;
  logic [31:0]            cur_stamp;
  logic [SW-1:0]          best_next;
  logic                   scan_last;
  logic [PAGE_BITS+OFFSET_BITS+31:0] xlate_wide;
  logic [PAGE_BITS+OFFSET_BITS+31:0] evict_wide;
  logic [PAGE_BITS+31:0]  key_wide;
  logic                   out_free;

  assign va_wide = {{PAGE_BITS{1'b0}}, vaddr} >> OFFSET_BITS;
  assign va_page = va_wide[PAGE_BITS-1:0];
  assign pn_wide = {{PAGE_BITS{1'b0}}, page_number};
  assign wp_wide = {{PAGE_BITS{1'b0}}, walk_page};
  assign l2_key  = cmd.demote_key ? f_vpage[v] : key;

  always_comb begin
    m1 = 1'b0;
    a  = '0;
    for (int i = FIRST_ENTRIES - 1; i >= 0; i--) begin
      if (f_valid[i] && f_vpage[i] == key) begin
        m1 = 1'b1;
        a  = W1'(i);
      end
    end
  end

  always_comb begin
    m2 = 1'b0;
    b  = '0;
    for (int i = SECOND_ENTRIES - 1; i >= 0; i--) begin
      if (s_valid[i] && s_vpage[i] == l2_key) begin
        m2 = 1'b1;
        b  = W2'(i);
      end
    end
  end

  assign cur_valid = cmd.scan_l2 ? s_valid[idx[W2-1:0]] : f_valid[idx[W1-1:0]];
  assign cur_stamp = cmd.scan_l2 ? s_stamp[idx[W2-1:0]] : f_stamp[idx[W1-1:0]];
  assign best_next = (!cur_valid || cur_stamp < oldest) ? idx : best;
  assign scan_last = !cur_valid ||
                     (idx == (cmd.scan_l2 ? SW'(SECOND_ENTRIES - 1) : SW'(FIRST_ENTRIES - 1)));

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    sts.l1_hit      = m1;
    sts.l1_dirty    = f_dirty[a];
    sts.l2_hit      = m2;
    sts.l2_dirty    = s_dirty[b];
    sts.scan_last   = scan_last;
    sts.v_valid     = f_valid[v];
    sts.evict_dirty = s_valid[k] && s_dirty[k];
    sts.out_free    = out_free;
  end

  assign xlate_wide = {32'b0, pp, off};
  assign evict_wide = {32'b0, s_ppage[k], {OFFSET_BITS{1'b0}}};
  assign key_wide   = {32'b0, key};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FIRST_ENTRIES; i++) begin
        f_valid[i] <= 1'b0;
        f_stamp[i] <= '0;
      end
      for (int i = 0; i < SECOND_ENTRIES; i++) begin
        s_valid[i] <= 1'b0;
        s_stamp[i] <= '0;
      end
      clock     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept && (op == OP_READ || op == OP_STORE)) begin
        clock <= clock + 32'd1;
      end
      if (cmd.look) begin
        if (m1) begin
          f_stamp[a] <= clock;
        end else if (m2) begin
          s_stamp[b] <= clock;
        end
      end
      if (cmd.fill_new || cmd.demote_fill) begin
        s_valid[k] <= 1'b1;
        s_stamp[k] <= clock;
      end
      if (cmd.fill_first) begin
        f_valid[v] <= 1'b1;
        f_stamp[v] <= clock;
      end
      if (cmd.inv1 && m1) begin
        f_valid[a] <= 1'b0;
      end
      if (cmd.inv2 && m2) begin
        s_valid[b] <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key  <= (op == OP_INV) ? pn_wide[PAGE_BITS-1:0] : va_page;
      off  <= vaddr[OFFSET_BITS-1:0];
      wr   <= (op == OP_STORE);
      walk <= wp_wide[PAGE_BITS-1:0];
    end
    if (cmd.look) begin
      h1 <= m1;
      h2 <= !m1 && m2;
      if (m1) begin
        pp <= f_ppage[a];
        if (wr) begin
          f_dirty[a] <= 1'b1;
        end
      end else if (m2) begin
        pp <= s_ppage[b];
        bd <= s_dirty[b] || wr;
        if (wr) begin
          s_dirty[b] <= 1'b1;
        end
      end else begin
        pp <= walk;
        bd <= wr;
      end
    end
    if (cmd.scan_init) begin
      idx    <= SW'(1);
      best   <= '0;
      oldest <= cmd.scan_l2 ? s_stamp[0] : f_stamp[0];
    end
    if (cmd.scan_step) begin
      idx    <= idx + SW'(1);
      best   <= best_next;
      oldest <= cur_stamp < oldest ? cur_stamp : oldest;
      if (scan_last) begin
        if (cmd.scan_l2) begin
          k <= best_next[W2-1:0];
        end else begin
          v <= best_next[W1-1:0];
        end
      end
    end
    if (cmd.fill_new) begin
      s_dirty[k] <= wr;
      s_vpage[k] <= key;
      s_ppage[k] <= pp;
    end
    if (cmd.merge && f_dirty[v]) begin
      s_dirty[b] <= 1'b1;
    end
    if (cmd.demote_fill) begin
      s_dirty[k] <= f_dirty[v];
      s_vpage[k] <= f_vpage[v];
      s_ppage[k] <= f_ppage[v];
    end
    if (cmd.fill_first) begin
      f_dirty[v] <= bd;
      f_vpage[v] <= key;
      f_ppage[v] <= pp;
    end
    if (cmd.out_load) begin
      last <= cmd.out_last;
      case (cmd.out_sel)
        OUT_XLATE: begin
          kind    <= 1'b0;
          address <= xlate_wide[31:0];
          l1_hit  <= h1;
          l2_hit  <= h2;
        end
        OUT_EVICT: begin
          kind    <= 1'b1;
          address <= evict_wide[31:0];
          l1_hit  <= 1'b0;
          l2_hit  <= 1'b0;
        end
        default: begin
          kind    <= 1'b1;
          address <= key_wide[31:0];
          l1_hit  <= 1'b0;
          l2_hit  <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* test/tlb_checker.sv */
// ----------------------------------------------------------------------------
// Two-level TLB checker
// Watches the request and result channels, keeps its own copy of both
// translation levels with their LRU stamps, predicts the results of every
// accepted request and compares each accepted result with the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlb_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  op,
  input  logic [31:0] vaddr,
  input  logic [19:0] page_number,
  input  logic [19:0] walk_page,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        kind,
  input  logic [31:0] address,
  input  logic        l1_hit,
  input  logic        l2_hit,
  input  logic        last,
  output int          errors,
  output int          pending
);
  import tlru_pkg::*;

  localparam int L1N = 8;
  localparam int L2N = 32;

  typedef struct packed {
    logic        kind;
    logic [31:0] address;
    logic        l1_hit;
    logic        l2_hit;
    logic        last;
  } tlb_result_t;

  logic        l1_v[L1N], l1_d[L1N];
  logic [19:0] l1_vp[L1N], l1_pp[L1N];
  logic [31:0] l1_ts[L1N];
  logic        l2_v[L2N], l2_d[L2N];
  logic [19:0] l2_vp[L2N], l2_pp[L2N];
  logic [31:0] l2_ts[L2N];
  logic [31:0] stamp_now;

  tlb_result_t expected_results[$];
  tlb_result_t batch[$];

  function automatic int l1_lru();
    int best;
    best = 0;
    for (int i = 1; i < L1N; i++) begin
      if (!l1_v[i]) return i;
      if (l1_ts[i] < l1_ts[best]) best = i;
    end
    return best;
  endfunction

  function automatic int l2_lru();
    int best;
    best = 0;
    for (int i = 1; i < L2N; i++) begin
      if (!l2_v[i]) return i;
      if (l2_ts[i] < l2_ts[best]) best = i;
    end
    return best;
  endfunction

  function automatic int l1_find(logic [19:0] key);
    for (int i = 0; i < L1N; i++) if (l1_v[i] && l1_vp[i] == key) return i;
    return -1;
  endfunction

  function automatic int l2_find(logic [19:0] key);
    for (int i = 0; i < L2N; i++) if (l2_v[i] && l2_vp[i] == key) return i;
    return -1;
  endfunction

  task automatic add_result(logic k, logic [31:0] a, logic h1, logic h2);
    tlb_result_t r;
    r = '{k, a, h1, h2, 1'b0};
    batch.push_back(r);
  endtask

  task automatic l2_fill(int k, logic dty, logic [19:0] vp, logic [19:0] pp);
    if (l2_v[k] && l2_d[k]) add_result(1'b1, {l2_pp[k], 12'h000}, 1'b0, 1'b0);
    l2_v[k] = 1'b1;
    l2_d[k] = dty;
    l2_vp[k] = vp;
    l2_pp[k] = pp;
    l2_ts[k] = stamp_now;
  endtask

  task automatic l1_demote(int i);
    int e;
    if (!l1_v[i]) return;
    e = l2_find(l1_vp[i]);
    if (e >= 0) begin
      if (l1_d[i]) l2_d[e] = 1'b1;
    end else begin
      l2_fill(l2_lru(), l1_d[i], l1_vp[i], l1_pp[i]);
    end
  endtask

  task automatic l1_fill(int i, logic dty, logic [19:0] vp, logic [19:0] pp);
    l1_v[i] = 1'b1;
    l1_d[i] = dty;
    l1_vp[i] = vp;
    l1_pp[i] = pp;
    l1_ts[i] = stamp_now;
  endtask

  task automatic translate_request(logic [1:0] o, logic [31:0] va, logic [19:0] pn,
                                   logic [19:0] wp);
    int a, b, v;
    logic wr;
    logic [19:0] vp, pp;
    logic [11:0] off;
    batch.delete();
    if (o == OP_INV) begin
      a = l1_find(pn);
      if (a >= 0) begin
        if (l1_d[a]) add_result(1'b1, {12'h000, pn}, 1'b0, 1'b0);
        l1_v[a] = 1'b0;
      end
      b = l2_find(pn);
      if (b >= 0) begin
        if (l2_d[b]) add_result(1'b1, {12'h000, pn}, 1'b0, 1'b0);
        l2_v[b] = 1'b0;
      end
    end else if (o != OP_NONE) begin
      wr = (o == OP_STORE);
      vp = va[31:12];
      off = va[11:0];
      stamp_now++;
      a = l1_find(vp);
      if (a >= 0) begin
        l1_ts[a] = stamp_now;
        if (wr) l1_d[a] = 1'b1;
        add_result(1'b0, {l1_pp[a], off}, 1'b1, 1'b0);
      end else begin
        b = l2_find(vp);
        if (b >= 0) begin
          l2_ts[b] = stamp_now;
          if (wr) l2_d[b] = 1'b1;
          pp = l2_pp[b];
          v = l1_lru();
          l1_demote(v);
          l1_fill(v, l2_d[b], vp, pp);
          add_result(1'b0, {pp, off}, 1'b0, 1'b1);
        end else begin
          l2_fill(l2_lru(), wr, vp, wp);
          v = l1_lru();
          l1_demote(v);
          l1_fill(v, wr, vp, wp);
          add_result(1'b0, {wp, off}, 1'b0, 1'b0);
        end
      end
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) expected_results.push_back(batch[i]);
  endtask

  always @(posedge clk) begin
    tlb_result_t want;
    if (rst) begin
      for (int i = 0; i < L1N; i++) begin
        l1_v[i] = 1'b0; l1_d[i] = 1'b0; l1_vp[i] = '0; l1_pp[i] = '0; l1_ts[i] = '0;
      end
      for (int i = 0; i < L2N; i++) begin
        l2_v[i] = 1'b0; l2_d[i] = 1'b0; l2_vp[i] = '0; l2_pp[i] = '0; l2_ts[i] = '0;
      end
      stamp_now = '0;
      expected_results.delete();
      errors = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result kind=%0b address=%h", $time, kind, address);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (want.kind !== kind || want.address !== address || want.l1_hit !== l1_hit ||
              want.l2_hit !== l2_hit || want.last !== last) begin
            $display("%0t: mismatch expected kind=%0b address=%h l1=%0b l2=%0b last=%0b",
                     $time, want.kind, want.address, want.l1_hit, want.l2_hit, want.last);
            $display("%0t:          actual kind=%0b address=%h l1=%0b l2=%0b last=%0b",
                     $time, kind, address, l1_hit, l2_hit, last);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall)
        translate_request(op, vaddr, page_number, walk_page);
    end
    pending = expected_results.size();
  end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// Two-level TLB testbench
// Drives directed and random read, write and invalidate requests over a small
// page pool so that hits, promotions, demotions and dirty write-backs occur,
// with random gaps on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import tlru_pkg::*;

  logic        clk, rst;
  logic        in_valid, in_stall;
  logic [1:0]  op;
  logic [31:0] vaddr;
  logic [19:0] page_number, walk_page;
  logic        out_valid, out_stall;
  logic        kind, l1_hit, l2_hit, last;
  logic [31:0] address;
  int          errors, pending;
  int          idle_cycles;
  bit          stim_done;
  bit          hold_done;
  logic [19:0] page_pool[48];

  two_level_tlb_lru_unit uut (.*);

  tlb_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  task automatic send(logic [1:0] o, logic [31:0] va, logic [19:0] pn, logic [19:0] wp);
    op <= o;
    vaddr <= va;
    page_number <= pn;
    walk_page <= wp;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [19:0] pg;
    logic [1:0]  o;
    int          r;
    r = $urandom_range(0, 99);
    pg = ($urandom_range(0, 9) == 0) ? 20'($urandom) : page_pool[$urandom_range(0, 47)];
    if (r < 45) o = OP_READ;
    else if (r < 85) o = OP_STORE;
    else if (r < 97) o = OP_INV;
    else o = OP_NONE;
    send(o, {pg, 12'($urandom)}, ($urandom_range(0, 3) == 0) ? 20'($urandom) : pg,
         20'($urandom));
  endtask

  initial begin
    int n;
    in_valid = 1'b0;
    op = OP_READ;
    vaddr = '0;
    page_number = '0;
    walk_page = '0;
    rst = 1'b1;
    foreach (page_pool[i]) page_pool[i] = 20'($urandom);
    page_pool[0] = 20'h00000;
    page_pool[1] = 20'hFFFFF;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    send(OP_READ, 32'h0000_0000, 20'h0, 20'h00000);
    send(OP_STORE, 32'hFFFF_FFFF, 20'h0, 20'hFFFFF);
    send(OP_READ, 32'hFFFF_F123, 20'h0, 20'h12345);
    send(OP_STORE, 32'h0000_0FFF, 20'h0, 20'h55555);
    send(OP_NONE, 32'h1234_5678, 20'hFFFFF, 20'hAAAAA);
    send(OP_INV, 32'h0, 20'hFFFFF, 20'h0);
    send(OP_INV, 32'h0, 20'h00000, 20'h0);
    send(OP_INV, 32'h0, 20'h00000, 20'h0);
    send(OP_INV, 32'h0, 20'h54321, 20'hFFFFF);
    for (int i = 0; i < 12; i++)
      send(OP_STORE, {20'h10000 + 20'(i), 12'hABC}, 20'h0, 20'hF0000 + 20'(i));
    send(OP_READ, 32'h1000_0000, 20'h0, 20'h0);
    send(OP_READ, 32'h1000_3001, 20'h0, 20'h0);
    in_valid <= 1'b0;
    n = 0;
    while (n < 500) begin
      repeat (gap_len()) @(negedge clk);
      if ($urandom_range(0, 3) == 0) begin
        for (int j = 0; j < 40 && n < 500; j++) begin
          send_random();
          n++;
        end
      end else begin
        send_random();
        n++;
      end
      in_valid <= 1'b0;
    end
    stim_done = 1'b1;
  end

  initial begin
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    repeat (60) @(negedge clk);
    out_stall <= 1'b1;
    repeat (300) @(negedge clk);
    out_stall <= 1'b0;
    hold_done = 1'b1;
    forever begin
      repeat ($urandom_range(0, 3) == 0 ? 0 : gap_len()) @(negedge clk);
      out_stall <= 1'b1;
      repeat (($urandom_range(0, 2) == 0) ? gap_len() : 0) @(negedge clk);
      out_stall <= 1'b0;
      @(negedge clk);
    end
  end

  initial begin
    idle_cycles = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (stim_done && hold_done && pending == 0) begin
        repeat (120) @(posedge clk);
        if (errors == 0 && pending == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
      end
      if (idle_cycles >= 2000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule

/* two_level_tlb_lru_unit.f */
hw/rtl/tlru_pkg.sv
hw/rtl/tlru_ctrl.sv
hw/rtl/tlru_dp.sv
hw/rtl/two_level_tlb_lru_unit.sv
test/tlb_checker.sv
test/tb.sv
